// ===== rtl/core/mst_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the max-tracking stack.
package mst_pkg;

  localparam int DEPTH_DEF      = 64;
  localparam int VALUE_BITS_DEF = 32;

  // Operation codes on the input channel.
  typedef enum logic [1:0] {
    FUNC_PUSH    = 2'd0,
    FUNC_POP     = 2'd1,
    FUNC_POP_MAX = 2'd2
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic shift_down;  // push: every cell takes its upper neighbor
    logic shift_up;    // pop: every cell takes its lower neighbor
    logic scan;        // move the search token one cell deeper
    logic remove;      // drop the token cell, cells below move up
    logic settle;      // rebuild running maxima above the gap
  } cell_ctrl_t;

endpackage

// ===== rtl/core/mst_cell.sv =====
`timescale 1ns / 1ps
// One stack cell: entry value, running maximum of itself and all deeper cells.
module mst_cell #(
  parameter int VALUE_BITS = mst_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  mst_pkg::cell_ctrl_t          ctrl,
  input  logic                         occ,
  input  logic signed [VALUE_BITS-1:0] up_val,
  input  logic signed [VALUE_BITS-1:0] up_rmax,
  input  logic                         up_tok,
  input  logic signed [VALUE_BITS-1:0] dn_val,
  input  logic signed [VALUE_BITS-1:0] dn_rmax,
  input  logic                         dn_pend,
  input  logic                         dn_occ,
  output logic signed [VALUE_BITS-1:0] val,
  output logic signed [VALUE_BITS-1:0] rmax,
  output logic                         tok,
  output logic                         pend,
  output logic                         hit
);

  logic signed [VALUE_BITS-1:0] val_r, val_nxt;
  logic signed [VALUE_BITS-1:0] rmax_r, rmax_nxt;
  logic                         tok_r, tok_nxt;
  logic                         above_r, above_nxt;
  logic                         pend_r, pend_nxt;

  always_comb begin
    val_nxt   = val_r;
    rmax_nxt  = rmax_r;
    tok_nxt   = tok_r;
    above_nxt = above_r;
    pend_nxt  = pend_r;
    if (ctrl.shift_down) begin
      val_nxt  = up_val;
      rmax_nxt = up_rmax;
    end else if (ctrl.shift_up) begin
      val_nxt  = dn_val;
      rmax_nxt = dn_rmax;
    end else if (ctrl.scan) begin
      tok_nxt   = up_tok;
      above_nxt = above_r | tok_r;
    end else if (ctrl.remove) begin
      tok_nxt   = 1'b0;
      above_nxt = 1'b0;
      if (above_r) begin
        // deeper set lost the max: running max must be rebuilt
        pend_nxt = 1'b1;
      end else begin
        val_nxt  = dn_val;
        rmax_nxt = dn_rmax;
        pend_nxt = 1'b0;
      end
    end else if (ctrl.settle) begin
      if (pend_r && !dn_pend) begin
        if (dn_occ && (dn_rmax > val_r)) begin
          rmax_nxt = dn_rmax;
        end else begin
          rmax_nxt = val_r;
        end
        pend_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    rmax_r <= rmax_nxt;
    if (!rst_n) begin
      tok_r   <= 1'b0;
      above_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      tok_r   <= tok_nxt;
      above_r <= above_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign val  = val_r;
  assign rmax = rmax_r;
  assign tok  = tok_r;
  assign pend = pend_r;
  // first cell from the top whose value equals its running max holds the max
  assign hit  = tok_r & occ & (val_r == rmax_r);

endmodule

// ===== rtl/core/max_stack_unit.sv =====
`timescale 1ns / 1ps
// Top level of the max-tracking stack: cell chain, sequencer, result register.
//
// Usage:
//   Input channel (in_valid / in_stall / in_func / in_push_value) carries one
//   request: push, pop top or pop maximum. Every request yields exactly one
//   result on the output channel (out_valid / out_stall / out_*), holding the
//   removed value, the new top, the new maximum, the entry count and status.
//   Sequencing:
//     push, pop, unused code : execute, then the result is handed to the
//                              output register.
//     pop maximum            : execute, scan and settle, then hand over. The
//                              search token walks the chain one cell a
//                              cycle, then the running maxima above the gap
//                              ripple back up likewise.
//   in_stall is high while a request is being worked on; the block takes a
//   new request while a finished result still sits in the output register.
//   A stalled result holds; a finished request then waits for the slot.
//   Reset (rst_n low, synchronous) empties the stack and the output register.
//   No clearing pass: entries are only read below the entry count.
module max_stack_unit #(
  parameter int DEPTH      = mst_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = mst_pkg::VALUE_BITS_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_func,
  input  logic signed [VALUE_BITS-1:0] in_push_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [VALUE_BITS-1:0] out_removed_value,
  output logic signed [VALUE_BITS-1:0] out_top_value,
  output logic signed [VALUE_BITS-1:0] out_max_value,
  output logic [CW-1:0]                out_entry_count,
  output logic [1:0]                   out_status
);

  // One-hot sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_SETTLE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [1:0]                   func_r;
  logic signed [VALUE_BITS-1:0] pval_r;
  logic [CW-1:0]                count_r, count_nxt;
  logic signed [VALUE_BITS-1:0] removed_r, removed_nxt;
  logic [1:0]                   status_r, status_nxt;
  mst_pkg::cell_ctrl_t          ctrl;
  logic                         tok0_in;
  logic signed [VALUE_BITS-1:0] push_rmax;

  // Cell outputs, each read at a fixed neighbor position.
  logic signed [VALUE_BITS-1:0] val_a  [DEPTH];
  logic signed [VALUE_BITS-1:0] rmax_a [DEPTH];
  logic [DEPTH-1:0]             tok_v;
  logic [DEPTH-1:0]             pend_v;
  logic [DEPTH-1:0]             hit_v;
  logic [DEPTH-1:0]             occ_v;

  logic                         in_acc;
  logic                         out_free;

  logic                         out_valid_r;
  logic signed [VALUE_BITS-1:0] out_removed_r, out_top_r, out_max_r;
  logic [CW-1:0]                out_count_r;
  logic [1:0]                   out_status_r;

  assign in_acc   = in_valid & ~in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = ~out_valid_r | ~out_stall;

  // New top cell's running max on push.
  assign push_rmax = ((count_r == '0) || (pval_r > rmax_a[0])) ? pval_r : rmax_a[0];

  // ---------------- cell chain, index 0 is the top of stack ----------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_BITS-1:0] up_val, up_rmax, dn_val, dn_rmax;
    logic                         up_tok, dn_pend, dn_occ;

    assign occ_v[i] = (count_r > CW'(i));

    if (i == 0) begin : g_top
      assign up_val  = pval_r;
      assign up_rmax = push_rmax;
      assign up_tok  = tok0_in;
    end else begin : g_mid
      assign up_val  = val_a[i-1];
      assign up_rmax = rmax_a[i-1];
      assign up_tok  = tok_v[i-1];
    end

    if (i == DEPTH - 1) begin : g_bot
      assign dn_val  = val_a[i];
      assign dn_rmax = rmax_a[i];
      assign dn_pend = 1'b0;
      assign dn_occ  = 1'b0;
    end else begin : g_low
      assign dn_val  = val_a[i+1];
      assign dn_rmax = rmax_a[i+1];
      assign dn_pend = pend_v[i+1];
      assign dn_occ  = occ_v[i+1];
    end

    mst_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .occ     (occ_v[i]),
      .up_val  (up_val),
      .up_rmax (up_rmax),
      .up_tok  (up_tok),
      .dn_val  (dn_val),
      .dn_rmax (dn_rmax),
      .dn_pend (dn_pend),
      .dn_occ  (dn_occ),
      .val     (val_a[i]),
      .rmax    (rmax_a[i]),
      .tok     (tok_v[i]),
      .pend    (pend_v[i]),
      .hit     (hit_v[i])
    );
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    ctrl        = '0;
    tok0_in     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          removed_nxt = '0;
          status_nxt  = mst_pkg::STAT_OK;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_DONE;
        case (func_r)
          mst_pkg::FUNC_PUSH: begin
            if (count_r == CW'(DEPTH)) begin
              status_nxt = mst_pkg::STAT_FULL;  // dropped
            end else begin
              ctrl.shift_down = 1'b1;
              count_nxt       = count_r + CW'(1);
            end
          end
          mst_pkg::FUNC_POP: begin
            if (count_r == '0) begin
              status_nxt = mst_pkg::STAT_EMPTY;
            end else begin
              ctrl.shift_up = 1'b1;
              removed_nxt   = val_a[0];
              count_nxt     = count_r - CW'(1);
            end
          end
          mst_pkg::FUNC_POP_MAX: begin
            if (count_r == '0) begin
              status_nxt = mst_pkg::STAT_EMPTY;
            end else begin
              // token enters the top cell
              ctrl.scan = 1'b1;
              tok0_in   = 1'b1;
              state_nxt = ST_SCAN;
            end
          end
          default: begin
            state_nxt = ST_DONE;  // unused code: no change
          end
        endcase
      end
      ST_SCAN: begin
        if (|hit_v) begin
          ctrl.remove = 1'b1;
          removed_nxt = rmax_a[0];  // removed entry is the global max
          count_nxt   = count_r - CW'(1);
          state_nxt   = ST_SETTLE;
        end else begin
          ctrl.scan = 1'b1;
        end
      end
      ST_SETTLE: begin
        if (|pend_v) begin
          ctrl.settle = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      pval_r <= in_push_value;
    end
    removed_r <= removed_nxt;
    status_r  <= status_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      out_removed_r <= removed_r;
      out_top_r     <= (count_r == '0) ? '0 : val_a[0];
      out_max_r     <= (count_r == '0) ? '0 : rmax_a[0];
      out_count_r   <= count_r;
      out_status_r  <= status_r;
    end
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_top_value     = out_top_r;
  assign out_max_value     = out_max_r;
  assign out_entry_count   = out_count_r;
  assign out_status        = out_status_r;

endmodule

// ===== rtl/core/mst_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the max-tracking stack, bound to the top level.
module mst_chk #(
  parameter int DEPTH      = mst_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = mst_pkg::VALUE_BITS_DEF,
  localparam int CW        = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [1:0]                   in_func,
  input logic signed [VALUE_BITS-1:0] in_push_value,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [VALUE_BITS-1:0] out_removed_value,
  input logic signed [VALUE_BITS-1:0] out_top_value,
  input logic signed [VALUE_BITS-1:0] out_max_value,
  input logic [CW-1:0]                out_entry_count,
  input logic [1:0]                   out_status
);

  // stalled request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_func) && $stable(in_push_value))
    else $error("stalled request changed");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_removed_value)
      && $stable(out_top_value) && $stable(out_max_value)
      && $stable(out_entry_count) && $stable(out_status))
    else $error("stalled result changed");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_entry_count == '0 |-> out_top_value == '0 && out_max_value == '0)
    else $error("empty stack reports nonzero top or max");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mst_pkg::STAT_FULL |-> out_entry_count == CW'(DEPTH))
    else $error("push dropped while not full");

  a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == mst_pkg::STAT_EMPTY
      |-> out_entry_count == '0 && out_removed_value == '0)
    else $error("empty removal reports data");

endmodule

bind max_stack_unit mst_chk #(
  .DEPTH      (DEPTH),
  .VALUE_BITS (VALUE_BITS)
) u_mst_chk (.*);

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for max_stack_unit: random push/pop/pop-max traffic against a stack model.
module tb;
  import mst_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int VALUE_BITS  = VALUE_BITS_DEF;
  localparam int CW          = $clog2(DEPTH + 1);
  localparam int RANDOM_REQS = 1900;
  // Cycles with no handshake on either side before the run is declared hung.
  // Slowest legal stretch: pop-max from the bottom plus a full
  // receiver stall, far below this.
  localparam int HANG_LIMIT  = 2000;
  // Pop-max from the bottom of a full stack is the slowest request.
  localparam int DRAIN_CYCLES = 2 * DEPTH + 20;
  localparam int PRINT_CAP   = 100;

  // Unused operation code: the block reports state and changes nothing.
  localparam logic [1:0] FUNC_NOP = 2'd3;

  // One request on the input channel.
  typedef struct {
    logic [1:0]                   func;
    logic signed [VALUE_BITS-1:0] value;
  } stack_req_t;

  // What the block should report after one request.
  typedef struct {
    logic signed [VALUE_BITS-1:0] removed;
    logic signed [VALUE_BITS-1:0] top;
    logic signed [VALUE_BITS-1:0] peak;
    logic [CW-1:0]                count;
    status_t                      status;
  } stack_view_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_func = FUNC_PUSH;
  logic signed [VALUE_BITS-1:0] in_push_value = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [VALUE_BITS-1:0] out_removed_value;
  logic signed [VALUE_BITS-1:0] out_top_value;
  logic signed [VALUE_BITS-1:0] out_max_value;
  logic [CW-1:0]                out_entry_count;
  logic [1:0]                   out_status;

  max_stack_unit #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_push_value     (in_push_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_removed_value (out_removed_value),
    .out_top_value     (out_top_value),
    .out_max_value     (out_max_value),
    .out_entry_count   (out_entry_count),
    .out_status        (out_status)
  );

  always #10 clk = ~clk;

  // Requests waiting to be driven, and the views the block still owes us.
  stack_req_t  req_queue[$];
  stack_view_t stack_views[$];

  // Model copy of the stack; index 0 is the bottom.
  logic signed [VALUE_BITS-1:0] cells [DEPTH];
  int unsigned                  depth_now = 0;

  int n_total    = 0;
  int n_accepted = 0;
  int n_errors   = 0;
  int idle_cycles = 0;

  // Generator's running entry count, used only to shape the traffic.
  int gen_depth = 0;

  // Idle/stall pacing state for each side.
  int drv_pause = 0;
  int drv_run   = 0;
  bit drv_quiet = 1'b0;
  int mon_pause = 0;
  int mon_run   = 0;
  bit mon_quiet = 1'b0;
  stack_req_t  cur_req;
  stack_view_t want;

  // ---------------------------------------------------------------------
  // Stack model
  // ---------------------------------------------------------------------

  // Slot of the largest entry, nearest the top on ties. Needs depth_now > 0.
  function automatic int peak_slot();
    int best;
    best = depth_now - 1;
    for (int i = int'(depth_now) - 2; i >= 0; i--)
      if (cells[i] > cells[best]) best = i;
    return best;
  endfunction

  // Apply one accepted request and queue the view the block must report.
  function automatic void run_stack_op(logic [1:0] func, logic signed [VALUE_BITS-1:0] value);
    stack_view_t v;
    int          k;
    v.removed = '0;
    v.status  = STAT_OK;
    case (func)
      FUNC_PUSH: begin
        if (depth_now >= DEPTH) begin
          v.status = STAT_FULL;      // full: value dropped
        end else begin
          cells[depth_now] = value;
          depth_now++;
        end
      end
      FUNC_POP, FUNC_POP_MAX: begin
        if (depth_now == 0) begin
          v.status = STAT_EMPTY;
        end else if (func == FUNC_POP) begin
          depth_now--;
          v.removed = cells[depth_now];
        end else begin
          // pull out the peak, entries above it close the gap
          k = peak_slot();
          v.removed = cells[k];
          for (int i = k; i + 1 < int'(depth_now); i++) cells[i] = cells[i + 1];
          depth_now--;
        end
      end
      default: ;                     // unused code: nothing moves
    endcase
    if (depth_now == 0) begin
      v.top  = '0;
      v.peak = '0;
    end else begin
      v.top  = cells[depth_now - 1];
      v.peak = cells[peak_slot()];
    end
    v.count = CW'(depth_now);
    stack_views.push_back(v);
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  function automatic void add_req(logic [1:0] func, logic signed [VALUE_BITS-1:0] value);
    stack_req_t r;
    r.func  = func;
    r.value = value;
    req_queue.push_back(r);
    if (func == FUNC_PUSH && gen_depth < DEPTH) gen_depth++;
    if ((func == FUNC_POP || func == FUNC_POP_MAX) && gen_depth > 0) gen_depth--;
  endfunction

  function automatic logic [1:0] pick_removal();
    return $urandom_range(0, 1) ? FUNC_POP_MAX : FUNC_POP;
  endfunction

  // Value styles: 0 full range, 1 narrow band (lots of ties), 2 extremes,
  // 3 moderate spread.
  function automatic logic signed [VALUE_BITS-1:0] draw_value(int style);
    logic signed [VALUE_BITS-1:0] v;
    case (style)
      0: v = $urandom;
      1: v = int'($urandom_range(0, 6)) - 3;
      2: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(VALUE_BITS-1){1'b1}}};
          1: v = {1'b1, {(VALUE_BITS-1){1'b0}}};
          2: v = '0;
          default: v = '1;
        endcase
      end
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    return v;
  endfunction

  // Pause before the next request / after each result. Runs of quiet
  // (no pause at all) and runs of random pauses follow in random order.
  function automatic int draw_pause(inout int run_left, inout bit quiet);
    if (run_left == 0) begin
      run_left = $urandom_range(5, 60);
      quiet    = ($urandom_range(0, 2) == 0);
    end
    run_left--;
    return quiet ? 0 : $urandom_range(0, 11);
  endfunction

  task automatic flag_mismatch(input string what, input logic [VALUE_BITS-1:0] got,
                               input logic [VALUE_BITS-1:0] exp_val);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("%0t: %s mismatch: got %h, want %h", $time, what, got, exp_val);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents requests from req_queue, predicts on acceptance.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid      <= 1'b0;
      in_func       <= FUNC_PUSH;
      in_push_value <= '0;
      drv_pause = 0;
    end else begin
      if (in_valid && !in_stall) begin
        run_stack_op(in_func, in_push_value);
        n_accepted++;
        drv_pause = draw_pause(drv_run, drv_quiet);
      end
      // a stalled request holds; otherwise pick the next one or idle
      if (!in_valid || !in_stall) begin
        if (drv_pause > 0) begin
          drv_pause--;
          in_valid <= 1'b0;
        end else if (req_queue.size() > 0) begin
          cur_req = req_queue.pop_front();
          in_func       <= cur_req.func;
          in_push_value <= cur_req.value;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks each accepted result, drives random stall.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mon_pause = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (stack_views.size() == 0) begin
          flag_mismatch("unrequested result, status", VALUE_BITS'(out_status), '0);
        end else begin
          want = stack_views.pop_front();
          if (out_removed_value !== want.removed)
            flag_mismatch("removed_value", out_removed_value, want.removed);
          if (out_top_value !== want.top)
            flag_mismatch("top_value", out_top_value, want.top);
          if (out_max_value !== want.peak)
            flag_mismatch("max_value", out_max_value, want.peak);
          if (out_entry_count !== want.count)
            flag_mismatch("entry_count", VALUE_BITS'(out_entry_count), VALUE_BITS'(want.count));
          if (out_status !== want.status)
            flag_mismatch("status", VALUE_BITS'(out_status), VALUE_BITS'(want.status));
        end
        mon_pause = draw_pause(mon_run, mon_quiet);
      end
      // stall runs between results regardless of whether one is waiting
      if (mon_pause > 0) begin
        mon_pause--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Hang detector: no handshake on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin
    int style;
    int n_random;

    // Directed: removals on empty, unused code, value extremes, ties on
    // the peak (upper copy must go first), peak in the middle and at the
    // bottom, and draining back to empty.
    add_req(FUNC_POP,     '0);
    add_req(FUNC_POP_MAX, '1);
    add_req(FUNC_NOP,     '0);
    add_req(FUNC_PUSH,    {1'b1, {(VALUE_BITS-1){1'b0}}});
    add_req(FUNC_PUSH,    7);
    add_req(FUNC_PUSH,    0);
    add_req(FUNC_PUSH,    7);
    add_req(FUNC_PUSH,    -1);
    add_req(FUNC_NOP,     '1);
    add_req(FUNC_POP_MAX, '0);
    add_req(FUNC_POP_MAX, '0);
    add_req(FUNC_PUSH,    {1'b0, {(VALUE_BITS-1){1'b1}}});
    add_req(FUNC_PUSH,    {1'b1, {(VALUE_BITS-1){1'b0}}});
    add_req(FUNC_POP_MAX, '0);
    add_req(FUNC_POP,     '0);
    add_req(FUNC_POP,     '1);
    add_req(FUNC_POP,     '0);
    add_req(FUNC_POP,     '0);
    add_req(FUNC_POP_MAX, '0);
    add_req(FUNC_PUSH,    -5);
    add_req(FUNC_PUSH,    -9);
    add_req(FUNC_POP_MAX, '0);
    add_req(FUNC_POP_MAX, '0);
    add_req(FUNC_POP,     '0);

    // Random: segments that climb to full, drain to empty, or wander.
    n_random = 0;
    while (n_random < RANDOM_REQS) begin
      style = $urandom_range(0, 3);
      n_random -= req_queue.size();
      if ($urandom_range(0, 3) == 0) add_req(FUNC_NOP, $urandom);
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // climb to full with the odd removal, then push into a full stack
          while (gen_depth < DEPTH) begin
            if ($urandom_range(0, 9) == 0) add_req(pick_removal(), $urandom);
            else add_req(FUNC_PUSH, draw_value(style));
          end
          repeat ($urandom_range(1, 3)) add_req(FUNC_PUSH, draw_value(style));
        end
        3, 4: begin
          // drain to empty and keep removing
          while (gen_depth > 0) add_req(pick_removal(), $urandom);
          repeat ($urandom_range(1, 2)) add_req(pick_removal(), $urandom);
        end
        default: begin
          repeat ($urandom_range(20, 80)) begin
            if ($urandom_range(0, 1)) add_req(FUNC_PUSH, draw_value(style));
            else add_req(pick_removal(), draw_value(style));
          end
        end
      endcase
      n_random += req_queue.size();
    end
    n_total = req_queue.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // every request in and every result back
    while (n_accepted < n_total || stack_views.size() != 0) @(negedge clk);
    // let any late extra result show up
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_errors == 0 && stack_views.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/mst_pkg.sv
rtl/core/mst_cell.sv
rtl/core/max_stack_unit.sv
rtl/core/mst_chk.sv
bench/tb.sv
